>>> design/gbs_pkg.sv
// Shared types and constants for the greedy box suppression block.
`default_nettype none
package gbs_pkg;
  localparam int MAX_BOXES = 64;
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int THR_W = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd42598;

  typedef struct packed {
    logic signed [31:0] s;
    logic [11:0] h;
    logic [11:0] w;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  typedef struct packed {
    logic valid;
    logic keep;
    logic done;
    box_t box;
  } cell_state_t;

  localparam logic [1:0] OP_HOLD    = 2'd0;
  localparam logic [1:0] OP_INSERT  = 2'd1;
  localparam logic [1:0] OP_JUDGE   = 2'd2;
  localparam logic [1:0] OP_ADVANCE = 2'd3;
endpackage
`default_nettype wire

>>> design/greedy_box_suppression.sv
// Top level: box load by sorted insertion, greedy suppression passes, kept-box output.
//  channel   dir  handshake         payload
//  s_axis    in   tvalid/tready     tdata box, tlast list end
//  m_axis    out  tvalid/tready     tdata kept box, tlast last kept, tuser overflow
//  cfg       in   cfg_wr_en         cfg_wr_data threshold (Q0.16)
// Load: one word per cycle, insertion into the ranked cell chain.
// After the list end: MAX_BOXES passes (overlap pipeline fill, judge, then rotate),
// then MAX_BOXES output steps, each held while a kept box waits on m_axis_tready.
// s_axis_tready is low from list end until output stepping finishes.
// rst is synchronous and clears the chain, count and output valid flag.
`default_nettype none
module greedy_box_suppression (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  input  wire logic [87:0] s_axis_tdata, // box_x, box_y, box_width, box_height, box_score
  input  wire logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  output logic [87:0] m_axis_tdata, // kept_x, kept_y, kept_width, kept_height, kept_score
  output logic m_axis_tlast,
  output logic m_axis_tuser,        // capacity_overflow
  input  wire logic cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);
  localparam int N = gbs_pkg::MAX_BOXES;
  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_PASS = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state;
  logic [gbs_pkg::CNT_W-1:0] count, step;
  logic [2:0] phase;
  logic ovf;
  logic [gbs_pkg::THR_W-1:0] thr;
  logic [1:0] op;
  gbs_pkg::cell_state_t cs [N];
  gbs_pkg::cell_state_t lft [N];
  gbs_pkg::cell_state_t rgt [N];
  logic gt [N];
  logic gtl [N];
  gbs_pkg::box_t new_box;
  logic accept, head_kept, rest_kept, emit_step, load_out;

  assign new_box = gbs_pkg::box_t'(s_axis_tdata);
  assign s_axis_tready = (state == ST_LOAD);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign head_kept = cs[0].valid && cs[0].keep;
  assign emit_step = (state == ST_EMIT) && (!head_kept || !m_axis_tvalid || m_axis_tready);
  assign load_out = emit_step && head_kept;

  always_comb begin
    rest_kept = 1'b0;
    for (int j = 1; j < N; j++) rest_kept = rest_kept | (cs[j].valid & cs[j].keep);
  end

  always_comb begin
    op = gbs_pkg::OP_HOLD;
    case (state)
      ST_LOAD: if (accept && (count < gbs_pkg::CNT_W'(N))) op = gbs_pkg::OP_INSERT;
      ST_PASS: begin
        if (phase == 3'd3) op = gbs_pkg::OP_JUDGE;
        else if (phase == 3'd4) op = gbs_pkg::OP_ADVANCE;
      end
      ST_EMIT: if (emit_step) op = gbs_pkg::OP_ADVANCE;
      default: op = gbs_pkg::OP_HOLD;
    endcase
  end

  always_comb begin
    for (int j = 0; j < N; j++) begin
      lft[j] = (j == 0) ? '0 : cs[(j == 0) ? 0 : j - 1];
      gtl[j] = (j == 0) ? 1'b0 : gt[(j == 0) ? 0 : j - 1];
      rgt[j] = (j == N - 1) ? '0 : cs[(j == N - 1) ? 0 : j + 1];
    end
    if (state == ST_PASS) begin
      rgt[N-1] = cs[0];
      rgt[N-1].done = 1'b1;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    gbs_cell u_cell (
      .clk(clk), .rst(rst), .op(op), .head(g == 0), .new_box(new_box),
      .gt_left(gtl[g]), .left(lft[g]), .right(rgt[g]), .pivot(cs[0]), .thr(thr),
      .st(cs[g]), .gt(gt[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= gbs_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      step <= '0;
      phase <= '0;
      ovf <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (count < gbs_pkg::CNT_W'(N)) count <= count + 1'b1;
            else ovf <= 1'b1;
            if (s_axis_tlast) begin
              state <= ST_PASS;
              step <= '0;
              phase <= '0;
            end
          end
        end
        ST_PASS: begin
          if (phase == 3'd4) begin
            phase <= '0;
            step <= step + 1'b1;
            if (step == gbs_pkg::CNT_W'(N - 1)) begin
              state <= ST_EMIT;
              step <= '0;
            end
          end else begin
            phase <= phase + 1'b1;
          end
        end
        ST_EMIT: begin
          if (emit_step) begin
            step <= step + 1'b1;
            if (step == gbs_pkg::CNT_W'(N - 1)) begin
              state <= ST_LOAD;
              count <= '0;
              ovf <= 1'b0;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= cs[0].box;
      m_axis_tlast <= !rest_kept;
      m_axis_tuser <= ovf;
    end
  end
endmodule
`default_nettype wire

>>> design/gbs_cell.sv
// One chain cell: holds a ranked box and tests it against the pivot box.
`default_nettype none
module gbs_cell (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [1:0] op,
  input  wire logic head,
  input  wire gbs_pkg::box_t new_box,
  input  wire logic gt_left,
  input  wire gbs_pkg::cell_state_t left,
  input  wire gbs_pkg::cell_state_t right,
  input  wire gbs_pkg::cell_state_t pivot,
  input  wire logic [gbs_pkg::THR_W-1:0] thr,
  output gbs_pkg::cell_state_t st,
  output logic gt
);
  logic signed [17:0] iw_c, ih_c;
  logic [11:0] iw, ih;
  logic ov1, ov2, ov3;
  logic [23:0] ua, ub, u, o2, o3;
  logic [39:0] tu;
  logic hit;

  assign gt = !st.valid || (new_box.s > st.box.s);

  always_comb begin
    logic signed [17:0] ae, be, ab, bb;
    ae = 18'(pivot.box.x) + 18'(signed'({1'b0, pivot.box.w}));
    be = 18'(st.box.x) + 18'(signed'({1'b0, st.box.w}));
    ab = 18'(pivot.box.x);
    bb = 18'(st.box.x);
    iw_c = ((ae < be) ? ae : be) - ((ab > bb) ? ab : bb);
    ae = 18'(pivot.box.y) + 18'(signed'({1'b0, pivot.box.h}));
    be = 18'(st.box.y) + 18'(signed'({1'b0, st.box.h}));
    ab = 18'(pivot.box.y);
    bb = 18'(st.box.y);
    ih_c = ((ae < be) ? ae : be) - ((ab > bb) ? ab : bb);
  end

  // overlap pipeline, free running; state is steady over a pass
  always_ff @(posedge clk) begin
    iw  <= iw_c[11:0];
    ih  <= ih_c[11:0];
    ov1 <= (iw_c > 18'sd0) && (ih_c > 18'sd0);
    ua  <= pivot.box.w * pivot.box.h;
    ub  <= st.box.w * st.box.h;
    o2  <= iw * ih;
    u   <= (ua < ub) ? ua : ub;
    ov2 <= ov1;
    o3  <= o2;
    ov3 <= ov2;
    tu  <= thr * u;
  end

  assign hit = !head && st.valid && st.keep && !st.done && pivot.valid && pivot.keep &&
               !pivot.done && ov3 && ({o3, 16'b0} > tu);

  always_ff @(posedge clk) begin
    if (rst) begin
      st.valid <= 1'b0;
    end else begin
      case (op)
        gbs_pkg::OP_INSERT: begin
          if (gt) begin
            if (gt_left) st <= left;
            else st <= '{valid: 1'b1, keep: 1'b1, done: 1'b0, box: new_box};
          end
        end
        gbs_pkg::OP_JUDGE: begin
          if (hit) st.keep <= 1'b0;
        end
        gbs_pkg::OP_ADVANCE: st <= right;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> design/gbs_checker.sv
// Port-level checks for the greedy box suppression top level, bound to it.
`default_nettype none
module gbs_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic s_axis_tlast,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [87:0] m_axis_tdata,
  input wire logic m_axis_tlast
);
  a_ready_after_reset: assert property (@(posedge clk) $fell(rst) |-> s_axis_tready)
    else $error("input not ready after reset");
  a_busy_after_end: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input still ready after list end");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled output word changed");
endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_tlast(s_axis_tlast), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
